// File: hw/rtl/cfr_pkg.sv
`timescale 1ns / 1ps

package cfr_pkg;

  localparam int unsigned KEPT_BYTES   = 6;
  localparam int unsigned HEADER_BYTES = 2;
  localparam logic [7:0]  SYNC_RESET   = 8'h5B;
  localparam logic [7:0]  OPCODE_RESET = 8'h0A;

  // configuration register indexes
  localparam logic [7:0] REG_SYNC_VALUE  = 8'd0;
  localparam logic [7:0] REG_DATA_OPCODE = 8'd1;

  // input operation codes
  localparam logic OP_RX_BYTE  = 1'b0;
  localparam logic OP_REQ_SENT = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LEN     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CSUM    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_DATA_OK  = 3'd0,
    ST_OTHER_OK = 3'd1,
    ST_BAD_SUM  = 3'd2,
    ST_LATCHED  = 3'd3,
    ST_TOO_LONG = 3'd4
  } status_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  opcode;
    logic [15:0] voltage_reading;
    logic [15:0] current_reading;
    logic [7:0]  protect_state;
  } out_item_t;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] data_opcode;
  } cfg_t;

endpackage

// File: hw/rtl/cfr_parser.sv
`timescale 1ns / 1ps

module cfr_parser #(
  parameter int unsigned BUFFER_BYTES = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  cfr_pkg::cfg_t      cfg,
  input  logic               item_valid,
  input  cfr_pkg::in_item_t  item,
  output logic               res_valid,
  output cfr_pkg::out_item_t res
);

  localparam int unsigned MAX_LEN = BUFFER_BYTES - cfr_pkg::HEADER_BYTES - 1;
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);

  cfr_pkg::phase_t phase, phase_next;
  logic [LEN_W-1:0] payload_length, payload_length_next;
  logic [LEN_W-1:0] byte_index, byte_index_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       frame_bytes [cfr_pkg::KEPT_BYTES];
  logic [7:0]       frame_bytes_next [cfr_pkg::KEPT_BYTES];
  logic [15:0]      stored_voltage, stored_voltage_next;
  logic [15:0]      stored_current, stored_current_next;
  logic [7:0]       stored_protect, stored_protect_next;
  logic             done_latch, done_latch_next;

  logic [7:0]       b;
  logic             too_long;
  logic [LEN_W-1:0] idx_inc;
  logic [7:0]       opc;
  logic             emit;
  cfr_pkg::status_t status;
  logic [7:0]       opcode_out;

  assign b        = item.rx_byte;
  assign too_long = ({2'b00, b} > 10'(MAX_LEN));
  assign idx_inc  = byte_index + LEN_W'(1);
  assign opc      = (payload_length != '0) ? frame_bytes[0] : 8'd0;

  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    byte_index_next     = byte_index;
    running_sum_next    = running_sum;
    frame_bytes_next    = frame_bytes;
    stored_voltage_next = stored_voltage;
    stored_current_next = stored_current;
    stored_protect_next = stored_protect;
    done_latch_next     = done_latch;
    emit                = 1'b0;
    status              = cfr_pkg::ST_OTHER_OK;
    opcode_out          = 8'd0;
    if (item_valid) begin
      if (item.operation == cfr_pkg::OP_REQ_SENT) begin
        done_latch_next = 1'b0;
      end else begin
        case (phase)
          cfr_pkg::PH_HUNT: begin
            if (b == cfg.sync_value) begin
              for (int i = 0; i < cfr_pkg::KEPT_BYTES; i++) begin
                frame_bytes_next[i] = 8'd0;
              end
              running_sum_next    = b;
              byte_index_next     = '0;
              payload_length_next = '0;
              phase_next          = cfr_pkg::PH_LEN;
            end
          end
          cfr_pkg::PH_LEN: begin
            if (too_long) begin
              phase_next = cfr_pkg::PH_HUNT;
              emit       = 1'b1;
              status     = cfr_pkg::ST_TOO_LONG;
            end else begin
              payload_length_next = LEN_W'(b);
              running_sum_next    = running_sum + b;
              byte_index_next     = '0;
              phase_next          = (b == 8'd0) ? cfr_pkg::PH_CSUM : cfr_pkg::PH_PAYLOAD;
            end
          end
          cfr_pkg::PH_PAYLOAD: begin
            for (int i = 0; i < cfr_pkg::KEPT_BYTES; i++) begin
              if (byte_index == LEN_W'(i)) begin
                frame_bytes_next[i] = b;
              end
            end
            running_sum_next = running_sum + b;
            byte_index_next  = idx_inc;
            if (idx_inc >= payload_length) begin
              phase_next = cfr_pkg::PH_CSUM;
            end
          end
          cfr_pkg::PH_CSUM: begin
            phase_next = cfr_pkg::PH_HUNT;
            emit       = 1'b1;
            opcode_out = opc;
            if (b != running_sum) begin
              status = cfr_pkg::ST_BAD_SUM;
            end else if (done_latch) begin
              status = cfr_pkg::ST_LATCHED;
            end else begin
              done_latch_next = 1'b1;
              if (payload_length != '0 && opc == cfg.data_opcode) begin
                stored_voltage_next = {frame_bytes[2], frame_bytes[1]};
                stored_current_next = {frame_bytes[4], frame_bytes[3]};
                stored_protect_next = frame_bytes[5];
                status              = cfr_pkg::ST_DATA_OK;
              end
            end
          end
          default: begin
            phase_next = cfr_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  assign res_valid = emit;
  assign res       = '{status: status, opcode: opcode_out,
                       voltage_reading: stored_voltage_next,
                       current_reading: stored_current_next,
                       protect_state: stored_protect_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= cfr_pkg::PH_HUNT;
      payload_length <= '0;
      byte_index     <= '0;
      running_sum    <= 8'd0;
      for (int i = 0; i < cfr_pkg::KEPT_BYTES; i++) begin
        frame_bytes[i] <= 8'd0;
      end
      stored_voltage <= 16'd0;
      stored_current <= 16'd0;
      stored_protect <= 8'd0;
      done_latch     <= 1'b0;
    end else begin
      phase          <= phase_next;
      payload_length <= payload_length_next;
      byte_index     <= byte_index_next;
      running_sum    <= running_sum_next;
      frame_bytes    <= frame_bytes_next;
      stored_voltage <= stored_voltage_next;
      stored_current <= stored_current_next;
      stored_protect <= stored_protect_next;
      done_latch     <= done_latch_next;
    end
  end

endmodule

// File: hw/rtl/cfr_out_queue.sv
`timescale 1ns / 1ps

module cfr_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cfr_pkg::out_item_t push_data,
  output logic               has_room,
  output logic               out_valid,
  input  logic               out_ready,
  output cfr_pkg::out_item_t out_data
);

  // head register drives the port, skid register catches a result when head stalls
  cfr_pkg::out_item_t head, skid;
  logic               head_valid, skid_valid;
  logic               pop;

  assign out_valid = head_valid;
  assign out_data  = head;
  assign has_room  = !skid_valid;
  assign pop       = head_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          head_valid <= 1'b1;
          skid_valid <= push;
        end else begin
          head_valid <= push;
        end
      end else if (push) begin
        if (head_valid) begin
          skid_valid <= 1'b1;
        end else begin
          head_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
        if (push) begin
          skid <= push_data;
        end
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      if (head_valid) begin
        skid <= push_data;
      end else begin
        head <= push_data;
      end
    end
  end

endmodule

// File: hw/rtl/checksum_frame_receiver.sv
`timescale 1ns / 1ps

// channel  direction  payload                      handshake
// cfg      in         cfg_index[7:0], cfg_data     cfg_valid / cfg_ready (always ready)
// in       in         in_data (operation, rx_byte) in_valid / in_ready
// out      out        out_data (status ... protect) out_valid / out_ready
//
// one request per cycle while in_ready is high: the parser state updates in the accepting
// cycle and the result, if any, lands in a two-entry output register the cycle after
// in_ready drops only while both output entries hold undelivered results
// synchronous active-high reset clears parser state, readings, latch, and restores config defaults
// config writes take effect on the next cycle

module checksum_frame_receiver #(
  parameter int unsigned BUFFER_BYTES = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  cfr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cfr_pkg::out_item_t out_data
);

  cfr_pkg::cfg_t      cfg;
  logic               accept;
  logic               res_valid;
  cfr_pkg::out_item_t res;
  logic               has_room;

  assign cfg_ready = 1'b1;
  assign in_ready  = has_room;
  assign accept    = in_valid && has_room;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value  <= cfr_pkg::SYNC_RESET;
      cfg.data_opcode <= cfr_pkg::OPCODE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        cfr_pkg::REG_SYNC_VALUE:  cfg.sync_value  <= cfg_data;
        cfr_pkg::REG_DATA_OPCODE: cfg.data_opcode <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame parser: sync hunt, length, payload, sum-8 check
  cfr_parser #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (accept),
    .item       (in_data),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register with skid entry
  cfr_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
